>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the subtractive generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked while out of reset.
`define SRG_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define SRG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define SRG_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define SRG_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> hw/rtl/srg_pkg.sv
// Package: constants, types and the modular subtract of the subtractive generator.
`default_nettype none

package srg_pkg;

    localparam int VAL_W     = 30;
    localparam int SEED_W    = 28;
    localparam int TABLE_LEN = 55;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int PASS_W    = 2;

    localparam logic [VAL_W-1:0]  MODULUS     = VAL_W'(1000000000);
    localparam logic [SEED_W-1:0] SEED_BASE   = SEED_W'(161803398);
    localparam logic [IDX_W-1:0]  FILL_STRIDE = IDX_W'(21);
    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(TABLE_LEN - 1);
    localparam logic [IDX_W-1:0]  LAG_OFFSET  = IDX_W'(30);
    localparam logic [IDX_W-1:0]  LAG_START   = IDX_W'(31);
    localparam logic [IDX_W-1:0]  CURSOR_TOP  = IDX_W'(TABLE_LEN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WARM,
        ST_DRAW_RD,
        ST_DRAW_WR
    } t_state;

    // One cycle worth of table traffic: two reads and one write.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic [IDX_W-1:0]  rd_addr_a;
        logic [IDX_W-1:0]  rd_addr_b;
    } t_ram_req;

    // a - b modulo one billion, both operands below the modulus.
    function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] wide;
        begin
            if (a >= b) begin
                wide = {1'b0, a} - {1'b0, b};
            end else begin
                wide = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
            end
            sub_mod = wide[VAL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/srg_lag_ram.sv
// Lag table memory: two registered read ports, one write port.
`default_nettype none

module srg_lag_ram (
    input  wire logic                       i_clk,
    input  wire srg_pkg::t_ram_req          i_req,
    output logic [srg_pkg::VAL_W-1:0]       o_rd_data_a,
    output logic [srg_pkg::VAL_W-1:0]       o_rd_data_b
);

    logic [srg_pkg::VAL_W-1:0] mem [srg_pkg::TABLE_LEN];

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // register both reads (old data on a same-cycle write)
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= mem[i_req.rd_addr_a];
        o_rd_data_b <= mem[i_req.rd_addr_b];
    end

endmodule

`default_nettype wire

>>> hw/rtl/subtractive_random_generator_core.sv
// Draw: after the accept, a read state, then a write state that registers the result.
// No new request is taken until a draw is done: the lag table RAM read-modify-write.
// Reseed or first draw after reset adds 55 fill writes and 4 x 55 warm-up steps.
// Reset clears cursors (0 and 31), the seeded flag and the output valid flag; the table
// holds no reset value and is rebuilt before its first read.
`default_nettype none

`include "assert_macros.svh"

module subtractive_random_generator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_kind,
    input  wire logic [srg_pkg::SEED_W-1:0]    i_seed,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [srg_pkg::VAL_W-1:0]          o_value
);

    srg_pkg::t_state                r_state, n_state;
    srg_pkg::t_ram_req              w_req;
    logic [srg_pkg::VAL_W-1:0]      w_rd_a, w_rd_b, w_diff;
    logic                           w_accept, w_rebuild;

    logic [srg_pkg::IDX_W-1:0]      r_read_cur, r_lag_cur, n_read_cur, n_lag_cur;
    logic                           r_seeded;
    logic [srg_pkg::VAL_W-1:0]      r_m, r_k;
    logic [srg_pkg::IDX_W-1:0]      r_pos, r_fcnt, r_widx, w_other, w_pos_next;
    logic [srg_pkg::IDX_W:0]        w_pos_sum;
    logic [srg_pkg::PASS_W-1:0]     r_pass;
    logic                           r_wr_valid;
    logic [srg_pkg::IDX_W-1:0]      r_wr_addr;
    logic                           r_out_valid;
    logic [srg_pkg::VAL_W-1:0]      r_out_value;
    logic [srg_pkg::SEED_W-1:0]     w_seed_clamp;

    // take a request only when idle and the output slot is free or draining
    assign o_in_stall = !((r_state == srg_pkg::ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_rebuild  = i_kind || !r_seeded;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

    assign w_diff       = srg_pkg::sub_mod(w_rd_a, w_rd_b);
    assign w_seed_clamp = (i_seed > srg_pkg::SEED_BASE) ? srg_pkg::SEED_BASE : i_seed;

    // advance cursors with wrap from 55 back to 1
    assign n_read_cur = (r_read_cur == srg_pkg::CURSOR_TOP) ? srg_pkg::IDX_W'(1)
                                                             : r_read_cur + 1'b1;
    assign n_lag_cur  = (r_lag_cur == srg_pkg::CURSOR_TOP) ? srg_pkg::IDX_W'(1)
                                                            : r_lag_cur + 1'b1;

    // fill position steps by 21 modulo 55
    assign w_pos_sum  = {1'b0, r_pos} + {1'b0, srg_pkg::FILL_STRIDE};
    assign w_pos_next = (w_pos_sum >= (srg_pkg::IDX_W+1)'(srg_pkg::TABLE_LEN))
                        ? srg_pkg::IDX_W'(w_pos_sum - (srg_pkg::IDX_W+1)'(srg_pkg::TABLE_LEN))
                        : w_pos_sum[srg_pkg::IDX_W-1:0];

    // warm-up partner entry: (idx + 31) mod 55
    assign w_other = (r_widx <= srg_pkg::LAG_OFFSET - srg_pkg::IDX_W'(7))
                     ? r_widx + srg_pkg::LAG_START
                     : r_widx - srg_pkg::IDX_W'(24);

    srg_lag_ram u_ram (
        .i_clk       (i_clk),
        .i_req       (w_req),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_rebuild ? srg_pkg::ST_FILL : srg_pkg::ST_DRAW_RD;
                end
            end
            srg_pkg::ST_FILL: begin
                if (r_fcnt == srg_pkg::LAST_IDX) begin
                    n_state = srg_pkg::ST_WARM;
                end
            end
            srg_pkg::ST_WARM: begin
                if (r_widx == srg_pkg::LAST_IDX && r_pass == '1) begin
                    n_state = srg_pkg::ST_DRAW_RD;
                end
            end
            srg_pkg::ST_DRAW_RD: n_state = srg_pkg::ST_DRAW_WR;
            srg_pkg::ST_DRAW_WR: n_state = srg_pkg::ST_IDLE;
            default:             n_state = srg_pkg::ST_IDLE;
        endcase
    end

    // table traffic per state; pending difference writes land in the cycle after their read
    always_comb begin
        w_req.we        = r_wr_valid;
        w_req.wr_addr   = r_wr_addr;
        w_req.wr_data   = w_diff;
        w_req.rd_addr_a = r_widx;
        w_req.rd_addr_b = w_other;
        case (r_state)
            srg_pkg::ST_FILL: begin
                w_req.we = 1'b1;
                if (r_fcnt == '0) begin
                    w_req.wr_addr = srg_pkg::LAST_IDX;
                    w_req.wr_data = r_m;
                end else begin
                    w_req.wr_addr = r_pos - 1'b1;
                    w_req.wr_data = r_k;
                end
            end
            srg_pkg::ST_DRAW_RD: begin
                w_req.rd_addr_a = n_read_cur - 1'b1;
                w_req.rd_addr_b = n_lag_cur - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srg_pkg::ST_IDLE;
            r_read_cur  <= '0;
            r_lag_cur   <= srg_pkg::LAG_START;
            r_seeded    <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_valid <= (r_state == srg_pkg::ST_WARM) || (r_state == srg_pkg::ST_DRAW_RD);
            if (w_accept && w_rebuild) begin
                r_read_cur <= '0;
                r_lag_cur  <= srg_pkg::LAG_START;
                r_seeded   <= 1'b1;
            end else if (r_state == srg_pkg::ST_DRAW_RD) begin
                r_read_cur <= n_read_cur;
                r_lag_cur  <= n_lag_cur;
            end
            if (r_state == srg_pkg::ST_DRAW_WR) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers: fill recurrence, warm-up sweep, write address, result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m    <= srg_pkg::VAL_W'(srg_pkg::SEED_BASE - w_seed_clamp);
            r_k    <= srg_pkg::VAL_W'(1);
            r_pos  <= srg_pkg::FILL_STRIDE;
            r_fcnt <= '0;
            r_widx <= '0;
            r_pass <= '0;
        end
        if (r_state == srg_pkg::ST_FILL) begin
            r_fcnt <= r_fcnt + 1'b1;
            if (r_fcnt != '0) begin
                r_k   <= srg_pkg::sub_mod(r_m, r_k);
                r_m   <= r_k;
                r_pos <= w_pos_next;
            end
        end
        if (r_state == srg_pkg::ST_WARM) begin
            r_wr_addr <= r_widx;
            if (r_widx == srg_pkg::LAST_IDX) begin
                r_widx <= '0;
                r_pass <= r_pass + 1'b1;
            end else begin
                r_widx <= r_widx + 1'b1;
            end
        end
        if (r_state == srg_pkg::ST_DRAW_RD) begin
            r_wr_addr <= n_read_cur - 1'b1;
        end
        if (r_state == srg_pkg::ST_DRAW_WR) begin
            r_out_value <= w_diff;
        end
    end

    // checks
    `SRG_ASSERT_NOW(a_slot_free, i_clk, i_rst_n, r_state == srg_pkg::ST_DRAW_WR, !r_out_valid)
    `SRG_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, r_state == srg_pkg::ST_DRAW_WR, r_out_valid)
    `SRG_ASSERT_NOW(a_one_writer, i_clk, i_rst_n, r_state == srg_pkg::ST_FILL, !r_wr_valid)
    `SRG_ASSERT_NOW(a_cursor_lag, i_clk, i_rst_n, r_state == srg_pkg::ST_IDLE && r_seeded, (r_read_cur <= srg_pkg::IDX_W'(24) && r_lag_cur == r_read_cur + srg_pkg::LAG_START) || (r_read_cur > srg_pkg::IDX_W'(24) && r_lag_cur == r_read_cur - srg_pkg::IDX_W'(24)))

endmodule

`default_nettype wire
